[hdl/pws_pkg.sv]
// Shared types, constants and defaults for the projective warp sampler.
package pws_pkg;

    // Parameter defaults.
    localparam int SRC_WIDTH_DEF  = 512;
    localparam int SRC_HEIGHT_DEF = 512;
    localparam int FRAC_BITS_DEF  = 32;

    // Fixed field and datapath widths.
    localparam int COEF_W      = 48;
    localparam int NUM_COEF    = 8;
    localparam int NUM_W       = 64;
    localparam int PROD_W      = COEF_W + 13;
    localparam int WEIGHT_BITS = 16;
    localparam int STORE_BITS  = 9;
    localparam int BANK_AW     = 2 * (STORE_BITS - 1);
    localparam int BANK_DEPTH  = 1 << BANK_AW;
    localparam int PIX_W       = 24;
    localparam int MIDQ_DEPTH  = 4;
    localparam int OUTQ_DEPTH  = 4;
    localparam int APB_AW      = 6;
    localparam int APB_DW      = 64;

    // Item kinds.
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Register map.
    typedef enum logic [2:0] {
        REG_COEF_A,
        REG_COEF_B,
        REG_COEF_C,
        REG_COEF_D,
        REG_COEF_E,
        REG_COEF_F,
        REG_COEF_G,
        REG_COEF_H
    } reg_idx_t;

    typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_bank_t;

    // One input word.
    typedef struct packed {
        logic        kind;
        logic [8:0]  src_col;
        logic [8:0]  src_row;
        logic [7:0]  load_red;
        logic [7:0]  load_green;
        logic [7:0]  load_blue;
        logic [11:0] out_col;
        logic [11:0] out_row;
    } pws_in_t;

    // Load payload carried down the pipeline.
    typedef struct packed {
        logic [STORE_BITS-1:0] col;
        logic [STORE_BITS-1:0] row;
        logic [PIX_W-1:0]      pix;
    } pws_load_t;

    // Word passed from the front end to the back end.
    typedef struct packed {
        logic              kind;
        pws_load_t         load;
        logic [NUM_W-1:0]  nx;
        logic [NUM_W-1:0]  ny;
        logic [NUM_W-1:0]  w;
    } pws_mid_t;

    // One result word.
    typedef struct packed {
        logic       inside_res;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pws_res_t;

endpackage

[hdl/pws_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module pws_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/pws_fifo.sv]
// Small first-in first-out queue held in flip-flops.
module pws_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // Pointer and count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[hdl/pws_front.sv]
// Front end: accepts words and maps sample coordinates through the homography.
module pws_front
    import pws_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  coef_bank_t coef,
    input  logic       push,
    output logic       full,
    input  pws_in_t    item,
    output logic       mid_push,
    output pws_mid_t   mid_data,
    input  logic       mid_full
);

    logic                     en;
    logic                     accept;
    logic                     f1_valid_reg;
    pws_in_t                  f1_item_reg;
    logic signed [PROD_W-1:0] f1_prod_reg [6];
    logic signed [PROD_W-1:0] prod [6];
    logic signed [12:0]       col_s, row_s;
    logic                     f2_valid_reg;
    pws_mid_t                 f2_item_reg, f2_item_next;
    logic signed [NUM_W-1:0]  one_w;

    // The pipeline advances unless a finished word cannot enter the queue.
    assign en       = !(f2_valid_reg && mid_full);
    assign full     = !en;
    assign accept   = push && en;
    assign mid_push = f2_valid_reg && en;
    assign mid_data = f2_item_reg;

    // Stage one: the six coefficient products.
    assign col_s = $signed({1'b0, item.out_col});
    assign row_s = $signed({1'b0, item.out_row});

    always_comb
    begin
        prod[0] = $signed(coef[REG_COEF_A]) * col_s;
        prod[1] = $signed(coef[REG_COEF_B]) * row_s;
        prod[2] = $signed(coef[REG_COEF_D]) * col_s;
        prod[3] = $signed(coef[REG_COEF_E]) * row_s;
        prod[4] = $signed(coef[REG_COEF_G]) * col_s;
        prod[5] = $signed(coef[REG_COEF_H]) * row_s;
    end

    // Stage two: the three homogeneous terms.
    assign one_w = NUM_W'(1) <<< FRAC_BITS;

    always_comb
    begin
        f2_item_next.kind     = f1_item_reg.kind;
        f2_item_next.load.col = f1_item_reg.src_col;
        f2_item_next.load.row = f1_item_reg.src_row;
        f2_item_next.load.pix = {f1_item_reg.load_red, f1_item_reg.load_green,
                                 f1_item_reg.load_blue};
        f2_item_next.nx = NUM_W'(f1_prod_reg[0]) + NUM_W'(f1_prod_reg[1])
                        + NUM_W'($signed(coef[REG_COEF_C]));
        f2_item_next.ny = NUM_W'(f1_prod_reg[2]) + NUM_W'(f1_prod_reg[3])
                        + NUM_W'($signed(coef[REG_COEF_F]));
        f2_item_next.w  = NUM_W'(f1_prod_reg[4]) + NUM_W'(f1_prod_reg[5]) + one_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= accept;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_item_reg <= item;
            for (int i = 0; i < 6; i++)
            begin
                f1_prod_reg[i] <= prod[i];
            end
            f2_item_reg <= f2_item_next;
        end
    end

endmodule

[hdl/pws_back.sv]
// Back end: divides, tests bounds, reads the banked frame store and blends.
module pws_back
    import pws_pkg::*;
#(
    parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = SRC_HEIGHT_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     mid_empty,
    output logic     mid_pop,
    input  pws_mid_t mid_data,
    output logic     empty,
    input  logic     pop,
    output pws_res_t res
);

    localparam int SRC_MAX = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
    localparam int IBITS   = $clog2(SRC_MAX);
    localparam int QB      = IBITS + WEIGHT_BITS;
    localparam int CW      = NUM_W + QB;
    localparam int WT_W    = WEIGHT_BITS + 1;
    localparam int WW      = 2 * WT_W;
    localparam int ACC_W   = WW + 8 + 2;
    localparam logic [IBITS-1:0] LIM_X = IBITS'(SRC_WIDTH - 1);
    localparam logic [IBITS-1:0] LIM_Y = IBITS'(SRC_HEIGHT - 1);

    logic en;
    logic out_full;
    logic out_push;
    pws_res_t out_data;

    // Stage zero: sign normalisation of the division.
    logic             s0_valid_reg;
    logic             s0_kind_reg;
    pws_load_t        s0_load_reg;
    logic [NUM_W-1:0] s0_den_reg, s0_nx_reg, s0_ny_reg;
    logic             s0_badx_reg, s0_bady_reg;
    logic             wneg;
    logic [NUM_W-1:0] den_n, nx_n, ny_n;

    // Divider stages, index zero is the range check stage.
    logic             dv_valid_reg [QB+1];
    logic             dv_kind_reg  [QB+1];
    pws_load_t        dv_load_reg  [QB+1];
    logic [NUM_W-1:0] dv_den_reg   [QB+1];
    logic [CW-1:0]    dv_rx_reg    [QB+1];
    logic [CW-1:0]    dv_ry_reg    [QB+1];
    logic [QB-1:0]    dv_qx_reg    [QB+1];
    logic [QB-1:0]    dv_qy_reg    [QB+1];
    logic             dv_badx_reg  [QB+1];
    logic             dv_bady_reg  [QB+1];

    // Address stage.
    logic                   s2_valid_reg, s2_kind_reg, s2_out_reg;
    logic [WEIGHT_BITS-1:0] s2_xf_reg, s2_yf_reg;
    logic [1:0]             s2_sel_reg [4];
    logic [IBITS-1:0]       xi, yi, x2, y2;
    logic [WEIGHT_BITS-1:0] xf, yf;
    logic                   remx, remy, outx, outy;
    logic [STORE_BITS-1:0]  xs1, xs2, ys1, ys2;
    logic [1:0]             sel [4];
    logic [BANK_AW-1:0]     raddr [4];
    logic [PIX_W-1:0]       rdata [4];
    logic [3:0]             bank_we;
    logic [BANK_AW-1:0]     waddr;

    // Weight stage.
    logic             s3_valid_reg, s3_kind_reg, s3_out_reg;
    logic [PIX_W-1:0] s3_pix_reg [4];
    logic [WW-1:0]    s3_wt_reg  [4];
    logic [WT_W-1:0]  wx0, wx1, wy0, wy1;
    logic [WW-1:0]    wt [4];

    // Accumulate stage.
    logic             s4_valid_reg, s4_kind_reg, s4_out_reg;
    logic [ACC_W-1:0] s4_acc_reg [3];
    logic [ACC_W-1:0] acc [3];
    logic [ACC_W-1:0] rnd [3];
    logic [7:0]       chan [3];

    // The whole back end stalls only when a result cannot enter its queue.
    assign en      = !(s4_valid_reg && (s4_kind_reg == KIND_SAMPLE) && out_full);
    assign mid_pop = en && !mid_empty;

    // Normalise so that the denominator is positive.
    always_comb
    begin
        wneg  = mid_data.w[NUM_W-1];
        den_n = wneg ? (~mid_data.w + 1'b1) : mid_data.w;
        nx_n  = wneg ? (~mid_data.nx + 1'b1) : mid_data.nx;
        ny_n  = wneg ? (~mid_data.ny + 1'b1) : mid_data.ny;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= mid_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_kind_reg <= mid_data.kind;
            s0_load_reg <= mid_data.load;
            s0_den_reg  <= den_n;
            s0_nx_reg   <= nx_n;
            s0_ny_reg   <= ny_n;
            s0_badx_reg <= (mid_data.w == '0) || nx_n[NUM_W-1];
            s0_bady_reg <= (mid_data.w == '0) || ny_n[NUM_W-1];
        end
    end

    // Range check: a quotient of 2^IBITS or more lies outside in any case.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_kind_reg[0] <= s0_kind_reg;
            dv_load_reg[0] <= s0_load_reg;
            dv_den_reg[0]  <= s0_den_reg;
            dv_rx_reg[0]   <= CW'(s0_nx_reg) << WEIGHT_BITS;
            dv_ry_reg[0]   <= CW'(s0_ny_reg) << WEIGHT_BITS;
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
            dv_badx_reg[0] <= s0_badx_reg ||
                ({{IBITS{1'b0}}, s0_nx_reg} >= {s0_den_reg, {IBITS{1'b0}}});
            dv_bady_reg[0] <= s0_bady_reg ||
                ({{IBITS{1'b0}}, s0_ny_reg} >= {s0_den_reg, {IBITS{1'b0}}});
        end
    end

    // Restoring division, one quotient bit per stage for both coordinates.
    for (genvar s = 0; s < QB; s++)
    begin : g_div
        localparam int K = QB - 1 - s;
        logic [CW-1:0] dsh;
        logic          gex, gey;

        assign dsh = CW'(dv_den_reg[s]) << K;
        assign gex = (dv_rx_reg[s] >= dsh);
        assign gey = (dv_ry_reg[s] >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[s+1] <= dv_valid_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_kind_reg[s+1] <= dv_kind_reg[s];
                dv_load_reg[s+1] <= dv_load_reg[s];
                dv_den_reg[s+1]  <= dv_den_reg[s];
                dv_rx_reg[s+1]   <= gex ? (dv_rx_reg[s] - dsh) : dv_rx_reg[s];
                dv_ry_reg[s+1]   <= gey ? (dv_ry_reg[s] - dsh) : dv_ry_reg[s];
                dv_qx_reg[s+1]   <= {dv_qx_reg[s][QB-2:0], gex};
                dv_qy_reg[s+1]   <= {dv_qy_reg[s][QB-2:0], gey};
                dv_badx_reg[s+1] <= dv_badx_reg[s];
                dv_bady_reg[s+1] <= dv_bady_reg[s];
            end
        end
    end

    // Bounds test, neighbour coordinates and bank addressing.
    always_comb
    begin
        xi   = dv_qx_reg[QB][QB-1:WEIGHT_BITS];
        yi   = dv_qy_reg[QB][QB-1:WEIGHT_BITS];
        xf   = dv_qx_reg[QB][WEIGHT_BITS-1:0];
        yf   = dv_qy_reg[QB][WEIGHT_BITS-1:0];
        remx = (dv_rx_reg[QB] != '0);
        remy = (dv_ry_reg[QB] != '0);
        outx = dv_badx_reg[QB] || (xi > LIM_X) ||
               ((xi == LIM_X) && ((xf != '0) || remx));
        outy = dv_bady_reg[QB] || (yi > LIM_Y) ||
               ((yi == LIM_Y) && ((yf != '0) || remy));
        x2   = (xi == LIM_X) ? xi : xi + 1'b1;
        y2   = (yi == LIM_Y) ? yi : yi + 1'b1;
        xs1  = STORE_BITS'(xi);
        xs2  = STORE_BITS'(x2);
        ys1  = STORE_BITS'(yi);
        ys2  = STORE_BITS'(y2);
        sel[0] = {ys1[0], xs1[0]};
        sel[1] = {ys1[0], xs2[0]};
        sel[2] = {ys2[0], xs1[0]};
        sel[3] = {ys2[0], xs2[0]};
        for (int b = 0; b < 4; b++)
        begin
            raddr[b] = {((ys1[0] == b[1]) ? ys1[STORE_BITS-1:1] : ys2[STORE_BITS-1:1]),
                        ((xs1[0] == b[0]) ? xs1[STORE_BITS-1:1] : xs2[STORE_BITS-1:1])};
        end
    end

    // Loads write the frame store at the same stage at which samples read it.
    always_comb
    begin
        waddr = {dv_load_reg[QB].row[STORE_BITS-1:1], dv_load_reg[QB].col[STORE_BITS-1:1]};
        for (int b = 0; b < 4; b++)
        begin
            bank_we[b] = en && dv_valid_reg[QB] && (dv_kind_reg[QB] == KIND_LOAD) &&
                         ({dv_load_reg[QB].row[0], dv_load_reg[QB].col[0]} == 2'(b));
        end
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        pws_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (waddr),
            .wdata (dv_load_reg[QB].pix),
            .re    (en),
            .raddr (raddr[b]),
            .rdata (rdata[b])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= dv_valid_reg[QB];
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_kind_reg <= dv_kind_reg[QB];
            s2_out_reg  <= outx || outy;
            s2_xf_reg   <= xf;
            s2_yf_reg   <= yf;
            for (int i = 0; i < 4; i++)
            begin
                s2_sel_reg[i] <= sel[i];
            end
        end
    end

    // Bilinear weights for the four neighbours.
    always_comb
    begin
        wx1   = WT_W'(s2_xf_reg);
        wy1   = WT_W'(s2_yf_reg);
        wx0   = (WT_W'(1) << WEIGHT_BITS) - wx1;
        wy0   = (WT_W'(1) << WEIGHT_BITS) - wy1;
        wt[0] = WW'(wx0) * WW'(wy0);
        wt[1] = WW'(wx1) * WW'(wy0);
        wt[2] = WW'(wx0) * WW'(wy1);
        wt[3] = WW'(wx1) * WW'(wy1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_kind_reg <= s2_kind_reg;
            s3_out_reg  <= s2_out_reg;
            for (int i = 0; i < 4; i++)
            begin
                s3_pix_reg[i] <= rdata[s2_sel_reg[i]];
                s3_wt_reg[i]  <= wt[i];
            end
        end
    end

    // Weighted sums, one per colour channel.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            acc[ch] = '0;
            for (int i = 0; i < 4; i++)
            begin
                acc[ch] = acc[ch] + ACC_W'(s3_pix_reg[i][16-8*ch +: 8]) * ACC_W'(s3_wt_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_kind_reg <= s3_kind_reg;
            s4_out_reg  <= s3_out_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                s4_acc_reg[ch] <= acc[ch];
            end
        end
    end

    // Round half up, saturate, and zero the result for outside points.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            rnd[ch]  = (s4_acc_reg[ch] + (ACC_W'(1) << (2 * WEIGHT_BITS - 1)))
                       >> (2 * WEIGHT_BITS);
            chan[ch] = (rnd[ch] > ACC_W'(255)) ? 8'hFF : rnd[ch][7:0];
        end
        out_data.inside_res = !s4_out_reg;
        out_data.red        = s4_out_reg ? 8'h00 : chan[0];
        out_data.green      = s4_out_reg ? 8'h00 : chan[1];
        out_data.blue       = s4_out_reg ? 8'h00 : chan[2];
    end

    assign out_push = en && s4_valid_reg && (s4_kind_reg == KIND_SAMPLE);

    // Result queue.
    pws_fifo #(
        .WIDTH ($bits(pws_res_t)),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (out_data),
        .full  (out_full),
        .pop   (pop),
        .dout  (res),
        .empty (empty)
    );

endmodule

[hdl/projective_warp_bilinear_sampler_core.sv]
// Projective warp bilinear sampler: register file, front end, queue and back end.
// Throughput: one word per cycle, loads and samples alike, while results are taken.
// Path of a sample: front-end product and sum registers, the queue, sign normalisation,
// range check, per-bit divider stages, then address, weight and accumulate stages.
// Reset clears all control state and loads the identity homography; the frame store
// holds no reset value and must be loaded before it is sampled.
module projective_warp_bilinear_sampler_core
    import pws_pkg::*;
#(
    parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = SRC_HEIGHT_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              push,
    output logic              full,
    input  logic              kind,
    input  logic [8:0]        src_col,
    input  logic [8:0]        src_row,
    input  logic [7:0]        load_red,
    input  logic [7:0]        load_green,
    input  logic [7:0]        load_blue,
    input  logic [11:0]       out_col,
    input  logic [11:0]       out_row,
    output logic              empty,
    input  logic              pop,
    output logic              inside_res,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue
);

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << FRAC_BITS);
    // Identity homography: coef_a and coef_e at one, all others at zero.
    localparam coef_bank_t COEF_RESET = {{3{{COEF_W{1'b0}}}}, COEF_ONE,
                                         {3{{COEF_W{1'b0}}}}, COEF_ONE};

    coef_bank_t coef_reg;
    reg_idx_t   reg_idx;
    logic       cfg_wr;
    pws_in_t    in_item;
    pws_mid_t   mid_in, mid_out;
    logic       mid_push, mid_pop, mid_full, mid_empty;
    pws_res_t   res;

    // Configuration registers.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[APB_AW-1:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = APB_DW'(coef_reg[reg_idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else if (cfg_wr)
        begin
            coef_reg[reg_idx] <= pwdata[COEF_W-1:0];
        end
    end

    // Input word.
    always_comb
    begin
        in_item.kind       = kind;
        in_item.src_col    = src_col;
        in_item.src_row    = src_row;
        in_item.load_red   = load_red;
        in_item.load_green = load_green;
        in_item.load_blue  = load_blue;
        in_item.out_col    = out_col;
        in_item.out_row    = out_row;
    end

    pws_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .coef     (coef_reg),
        .push     (push),
        .full     (full),
        .item     (in_item),
        .mid_push (mid_push),
        .mid_data (mid_in),
        .mid_full (mid_full)
    );

    // Queue between the front and back ends.
    pws_fifo #(
        .WIDTH ($bits(pws_mid_t)),
        .DEPTH (MIDQ_DEPTH)
    ) u_midq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .din   (mid_in),
        .full  (mid_full),
        .pop   (mid_pop),
        .dout  (mid_out),
        .empty (mid_empty)
    );

    pws_back #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .mid_data  (mid_out),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign inside_res = res.inside_res;
    assign red        = res.red;
    assign green      = res.green;
    assign blue       = res.blue;

endmodule
